### hw/rtl/nrtl_pkg.sv
// nrtl_pkg: shared constants, codes and control structs of the nearest row lookup
// used by nrtl_ctrl, nrtl_dp and the top level
`default_nettype none
package nrtl_pkg;
  localparam int unsigned RowW   = 6;
  localparam int unsigned ElemW  = 4;
  localparam int unsigned TElemW = 3;
  localparam int unsigned ValW   = 16;
  localparam int unsigned AccW   = 40;
  localparam int unsigned SqW    = 2 * (ValW + 1);
  localparam logic [6:0] MaxRows = 7'd64;
  localparam logic [4:0] MaxKeyLen = 5'd16;
  localparam logic [3:0] MaxTgtLen = 4'd8;

  localparam logic [1:0] ActKey = 2'd0;
  localparam logic [1:0] ActTgt = 2'd1;
  localparam logic [1:0] ActQry = 2'd2;

  localparam logic [1:0] CfgOnehot = 2'd0;
  localparam logic [1:0] CfgRows   = 2'd1;
  localparam logic [1:0] CfgKeyLen = 2'd2;
  localparam logic [1:0] CfgTgtLen = 2'd3;

  typedef enum logic [2:0] {
    StIdle, StHot, StScan, StDrain, StEmit
  } state_e;

  typedef struct packed {
    logic              key_wr;
    logic              tgt_wr;
    logic              q_wr;
    logic              hot_step;
    logic              scan_vld;
    logic              first;
    logic              last;
    logic [RowW-1:0]   r;
    logic [ElemW-1:0]  j;
    logic              emit_vld;
    logic              emit_last;
    logic              err;
    logic              use_hot;
  } cmd_t;

  typedef struct packed {
    logic [ElemW-1:0] hot_idx;
  } stat_t;
endpackage
`default_nettype wire

### hw/rtl/nrtl_ctrl.sv
// nrtl_ctrl: configuration registers and sequencer of the nearest row lookup
// depends on nrtl_pkg
`default_nettype none
module nrtl_ctrl import nrtl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [ElemW-1:0]  element_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [6:0]        cfg_data_i,
  input  stat_t                  stat_i,
  output logic                   busy_o,
  output cmd_t                   cmd_o
);
  state_e state_q, state_d;
  logic [6:0] r_q, r_d;
  logic [4:0] j_q, j_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic       onehot_q;
  logic [6:0] rows_q;
  logic [4:0] klen_q;
  logic [3:0] tlen_q;
  logic [6:0] rows;
  logic [4:0] klen;
  logic [3:0] tlen;
  logic       acc;

  always_comb begin
    rows = (rows_q == 7'd0) ? 7'd1 : ((rows_q > MaxRows) ? MaxRows : rows_q);
    klen = (klen_q == 5'd0) ? 5'd1 : ((klen_q > MaxKeyLen) ? MaxKeyLen : klen_q);
    tlen = (tlen_q == 4'd0) ? 4'd1 : ((tlen_q > MaxTgtLen) ? MaxTgtLen : tlen_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      onehot_q <= 1'b0;
      rows_q   <= 7'd1;
      klen_q   <= 5'd16;
      tlen_q   <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOnehot: onehot_q <= cfg_data_i[0];
        CfgRows:   rows_q   <= cfg_data_i;
        CfgKeyLen: klen_q   <= cfg_data_i[4:0];
        CfgTgtLen: tlen_q   <= cfg_data_i[3:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      r_q     <= 7'd0;
      j_q     <= 5'd0;
      dcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      j_q     <= j_d;
      dcnt_q  <= dcnt_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign acc    = start_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    j_d     = j_q;
    dcnt_d  = dcnt_q;
    cmd_o   = '0;
    cmd_o.use_hot = onehot_q;
    cmd_o.r = r_q[RowW-1:0];
    cmd_o.j = j_q[ElemW-1:0];
    unique case (state_q)
      StIdle: begin
        cmd_o.key_wr = acc && (action_i == ActKey);
        cmd_o.tgt_wr = acc && (action_i == ActTgt) && !element_i[ElemW-1];
        cmd_o.q_wr   = acc && (action_i == ActQry);
        r_d = 7'd0;
        j_d = 5'd0;
        if (cmd_o.q_wr && ({1'b0, element_i} + 5'd1 == klen)) begin
          state_d = onehot_q ? StHot : StScan;
        end
      end
      StHot: begin
        if (j_q < klen) begin
          cmd_o.hot_step = 1'b1;
          j_d = j_q + 5'd1;
        end else if ({3'b000, stat_i.hot_idx} >= rows) begin
          cmd_o.err = 1'b1;
          state_d = StIdle;
        end else begin
          j_d = 5'd0;
          state_d = StEmit;
        end
      end
      StScan: begin
        cmd_o.scan_vld = 1'b1;
        cmd_o.first = (j_q == 5'd0);
        cmd_o.last  = (j_q + 5'd1 == klen);
        if (cmd_o.last) begin
          j_d = 5'd0;
          if (r_q + 7'd1 == rows) begin
            dcnt_d  = 2'd0;
            state_d = StDrain;
          end else begin
            r_d = r_q + 7'd1;
          end
        end else begin
          j_d = j_q + 5'd1;
        end
      end
      StDrain: begin
        dcnt_d = dcnt_q + 2'd1;
        if (dcnt_q == 2'd2) begin
          j_d = 5'd0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit_vld  = 1'b1;
        cmd_o.emit_last = (j_q + 5'd1 == {1'b0, tlen});
        j_d = j_q + 5'd1;
        if (cmd_o.emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/nrtl_dp.sv
// nrtl_dp: key and target memories, query buffer, distance pipeline and result registers
// depends on nrtl_pkg, driven by nrtl_ctrl
`default_nettype none
module nrtl_dp import nrtl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cmd_t                     cmd_i,
  input  wire logic [RowW-1:0]     row_i,
  input  wire logic [ElemW-1:0]    element_i,
  input  wire logic signed [ValW-1:0] value_i,
  output stat_t                    stat_o,
  output logic                     res_valid_o,
  output logic [TElemW-1:0]        element_res_o,
  output logic signed [ValW-1:0]   value_res_o,
  output logic                     last_o,
  output logic                     status_o,
  output logic [RowW-1:0]          chosen_row_o
);
  logic signed [ValW-1:0] kmem [2**(RowW+ElemW)];
  logic signed [ValW-1:0] tmem [2**(RowW+TElemW)];
  logic signed [ValW-1:0] qbuf [2**ElemW];

  logic signed [ValW-1:0] key_q, qv_q, tgt_q, hot_val_q;
  logic [ElemW-1:0]       hot_q;
  logic                   v1_q, v2_q, v3_q, f1_q, f2_q, l1_q, l2_q, l3_q;
  logic [RowW-1:0]        r1_q, r2_q, r3_q, best_row_q, emit_row;
  logic [SqW-1:0]         sq_q;
  logic [AccW-1:0]        acc_q, best_q;
  logic signed [ValW:0]   diff;
  logic signed [SqW-1:0]  prod;
  logic                   res_v_q, err_q, last_q;
  logic [TElemW-1:0]      elem_q;
  logic [RowW-1:0]        row_q;

  assign stat_o.hot_idx = hot_q;
  assign emit_row = cmd_i.use_hot ? {{(RowW-ElemW){1'b0}}, hot_q} : best_row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      kmem[{row_i, element_i}] <= value_i;
    end
    if (cmd_i.tgt_wr) begin
      tmem[{row_i, element_i[TElemW-1:0]}] <= value_i;
    end
    if (cmd_i.q_wr) begin
      qbuf[element_i] <= value_i;
    end
    key_q <= kmem[{cmd_i.r, cmd_i.j}];
    qv_q  <= qbuf[cmd_i.j];
    tgt_q <= tmem[{emit_row, cmd_i.j[TElemW-1:0]}];
  end

  always_comb begin
    diff = {qv_q[ValW-1], qv_q} - {key_q[ValW-1], key_q};
    prod = diff * diff;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hot_step) begin
      if (cmd_i.j == '0) begin
        hot_q     <= '0;
        hot_val_q <= qbuf[0];
      end else if (qbuf[cmd_i.j] > hot_val_q) begin
        hot_q     <= cmd_i.j;
        hot_val_q <= qbuf[cmd_i.j];
      end
    end
    f1_q <= cmd_i.first;
    l1_q <= cmd_i.last;
    r1_q <= cmd_i.r;
    f2_q <= f1_q;
    l2_q <= l1_q;
    r2_q <= r1_q;
    sq_q <= prod;
    l3_q <= l2_q;
    r3_q <= r2_q;
    if (v2_q) begin
      acc_q <= (f2_q ? '0 : acc_q) + {{(AccW-SqW){1'b0}}, sq_q};
    end
    if (v3_q && l3_q && ((r3_q == '0) || (acc_q < best_q))) begin
      best_q     <= acc_q;
      best_row_q <= r3_q;
    end
    elem_q <= cmd_i.j[TElemW-1:0];
    last_q <= cmd_i.emit_last || cmd_i.err;
    err_q  <= cmd_i.err;
    row_q  <= cmd_i.err ? {{(RowW-ElemW){1'b0}}, hot_q} : emit_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v1_q    <= cmd_i.scan_vld;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      res_v_q <= cmd_i.emit_vld || cmd_i.err;
    end
  end

  assign res_valid_o   = res_v_q;
  assign element_res_o = err_q ? '0 : elem_q;
  assign value_res_o   = err_q ? '0 : tgt_q;
  assign last_o        = last_q;
  assign status_o      = err_q;
  assign chosen_row_o  = row_q;
endmodule
`default_nettype wire

### hw/rtl/nearest_row_table_lookup_unit.sv
// nearest_row_table_lookup_unit: top level, joins sequencer and datapath
// depends on nrtl_pkg, nrtl_ctrl, nrtl_dp
//
// usage: an item (action, row, element, value) is taken when start_i is high and
// busy_o is low. a query element is stored in the query buffer; the element at
// key_length-1 starts an answer and holds busy_o.
// distance mode: the key memory is read one row-element per cycle, then the
// pipeline drains, then the target row of the nearest key row is emitted (one
// result per cycle, res_valid_o strobed, last_o on the final one). one-hot mode:
// the first maximum is found (one compare per cycle, then a decision), then
// either target_length results or one error result (status_o 1).
// each result is shown for exactly one cycle, in the cycle after it is read from
// the target memory; the receiver cannot stall. configuration writes
// (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and belong in idle time.
// reset returns the registers to their defaults and the sequencer to idle;
// memory contents are undefined until written.
`default_nettype none
module nearest_row_table_lookup_unit import nrtl_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             action_i,
  input  wire logic [RowW-1:0]        row_i,
  input  wire logic [ElemW-1:0]       element_i,
  input  wire logic signed [ValW-1:0] value_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [6:0]             cfg_data_i,
  output logic                        res_valid_o,
  output logic [TElemW-1:0]           element_res_o,
  output logic signed [ValW-1:0]      value_res_o,
  output logic                        last_o,
  output logic                        status_o,
  output logic [RowW-1:0]             chosen_row_o
);
  cmd_t  cmd;
  stat_t stat;

  nrtl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .action_i, .element_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .stat_i(stat), .busy_o, .cmd_o(cmd)
  );

  nrtl_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .row_i, .element_i, .value_i,
    .stat_o(stat), .res_valid_o, .element_res_o, .value_res_o,
    .last_o, .status_o, .chosen_row_o
  );
endmodule
`default_nettype wire

### hw/rtl/nrtl_checker.sv
// nrtl_checker: port level assertions on the result channel, bound to the top level
// depends on nearest_row_table_lookup_unit ports only
`default_nettype none
module nrtl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_o,
  input wire logic [2:0]  element_res_o,
  input wire logic [15:0] value_res_o,
  input wire logic        last_o,
  input wire logic        status_o
);
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o |-> last_o && element_res_o == 3'd0 && value_res_o == 16'd0)
    else $error("error result malformed");
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("answer burst broken");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> element_res_o == $past(element_res_o) + 3'd1)
    else $error("target elements out of order");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !res_valid_o || element_res_o == 3'd0)
    else $error("answer does not start at element zero");
endmodule

bind nearest_row_table_lookup_unit nrtl_checker u_nrtl_checker (
  .clk_i, .rst_ni, .res_valid_o, .element_res_o, .value_res_o, .last_o, .status_o
);
`default_nettype wire

### tb/tb.sv
// tb: self-checking testbench for nearest_row_table_lookup_unit, directed then random transfers
// predicts every answer from its own copy of the key, target and query stores
// depends on nrtl_pkg and the block's rtl
module tb;
  import nrtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [TElemW-1:0]      pos;
    logic signed [ValW-1:0] val;
    logic                   last;
    logic                   err;
    logic [RowW-1:0]        row;
  } answer_t;

  localparam int LoadRows = 6;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [1:0]             action_i = '0;
  logic [RowW-1:0]        row_i = '0;
  logic [ElemW-1:0]       element_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_idx_i = '0;
  logic [6:0]             cfg_data_i = '0;
  logic                   res_valid_o;
  logic [TElemW-1:0]      element_res_o;
  logic signed [ValW-1:0] value_res_o;
  logic                   last_o;
  logic                   status_o;
  logic [RowW-1:0]        chosen_row_o;

  logic signed [ValW-1:0] key_mem [64][16];
  logic signed [ValW-1:0] tgt_mem [64][8];
  logic signed [ValW-1:0] qry_buf [16];
  logic                   hot_mode = 1'b0;
  logic [6:0]             rows_reg = 7'd1;
  logic [4:0]             klen_reg = 5'd16;
  logic [3:0]             tlen_reg = 4'd8;

  answer_t answer_q[$];
  int      n_fail = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 0;

  nearest_row_table_lookup_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  function automatic int clamp(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic void push_row(int r, int tlen);
    answer_t a;
    for (int j = 0; j < tlen; j++) begin
      a.pos = TElemW'(j); a.val = tgt_mem[r][j]; a.last = (j == tlen - 1); a.err = 1'b0;
      a.row = RowW'(r);
      answer_q.push_back(a);
    end
  endfunction

  function automatic void lookup_predict(logic [1:0] act, logic [RowW-1:0] r,
                                         logic [ElemW-1:0] e, logic signed [ValW-1:0] v);
    int rows, klen, tlen, hot, best;
    longint d, best_d, diff;
    answer_t a;
    rows = clamp(rows_reg, 64);
    klen = clamp(klen_reg, 16);
    tlen = clamp(tlen_reg, 8);
    if (act == ActKey) begin
      key_mem[r][e] = v;
    end else if (act == ActTgt) begin
      if (e < 8) tgt_mem[r][e] = v;
    end else if (act == ActQry) begin
      qry_buf[e] = v;
      if (int'(e) + 1 != klen) return;
      if (hot_mode) begin
        hot = 0;
        for (int j = 1; j < klen; j++) if (qry_buf[j] > qry_buf[hot]) hot = j;
        if (hot >= rows) begin
          a.pos = '0; a.val = '0; a.last = 1'b1; a.err = 1'b1; a.row = RowW'(hot);
          answer_q.push_back(a);
        end else begin
          push_row(hot, tlen);
        end
      end else begin
        best = 0;
        best_d = 0;
        for (int rr = 0; rr < rows; rr++) begin
          d = 0;
          for (int j = 0; j < klen; j++) begin
            diff = longint'(qry_buf[j]) - longint'(key_mem[rr][j]);
            d += diff * diff;
          end
          if (rr == 0 || d < best_d) begin
            best_d = d;
            best = rr;
          end
        end
        push_row(best, tlen);
      end
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && res_valid_o) begin
      if (answer_q.size() == 0) begin
        report("unexpected result row", chosen_row_o, -1);
      end else begin
        a = answer_q.pop_front();
        if (element_res_o !== a.pos) report("element_res", element_res_o, a.pos);
        if (value_res_o !== a.val) report("value_res", value_res_o, a.val);
        if (last_o !== a.last) report("last", last_o, a.last);
        if (status_o !== a.err) report("status", status_o, a.err);
        if (chosen_row_o !== a.row) report("chosen_row", chosen_row_o, a.row);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return ValW'($urandom_range(3));
      default: return ValW'($urandom);
    endcase
  endfunction

  task automatic send(logic [1:0] act, logic [RowW-1:0] r, logic [ElemW-1:0] e,
                      logic [ValW-1:0] v);
    int gap;
    action_i <= act;
    row_i <= r;
    element_i <= e;
    value_i <= v;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    lookup_predict(act, r, e, v);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgOnehot: hot_mode = data[0];
      CfgRows:   rows_reg = data;
      CfgKeyLen: klen_reg = data[4:0];
      CfgTgtLen: tlen_reg = data[3:0];
    endcase
  endtask

  task automatic query_all(logic [ValW-1:0] v);
    for (int j = 0; j < clamp(klen_reg, 16); j++) send(ActQry, 0, j, v + j);
  endtask

  // fills the key and target rows that any later lookup may read
  task automatic test_load();
    no_gaps = 1;
    for (int r = 0; r < LoadRows; r++) begin
      for (int j = 0; j < 16; j++) send(ActKey, r, j, pick_value());
      for (int j = 0; j < 8; j++) send(ActTgt, r, j, pick_value());
    end
    no_gaps = 0;
  endtask

  task automatic test_directed();
    cfg_write(CfgRows, 7'(LoadRows));
    send(ActKey, 63, 15, 16'h8000);
    send(ActTgt, 63, 7, 16'h7fff);
    send(ActTgt, 5, 12, 16'h1234);
    send(2'd3, 6'h3f, 4'hf, 16'hffff);
    query_all(16'h8000);
    cfg_write(CfgKeyLen, 7'd1);
    send(ActKey, 0, 0, 16'h0100);
    send(ActKey, 1, 0, 16'h0100);
    send(ActQry, 0, 0, 16'h0100);
    send(ActQry, 0, 9, 16'h7fff);
    cfg_write(CfgOnehot, 7'd1);
    cfg_write(CfgRows, 7'd3);
    cfg_write(CfgKeyLen, 7'd8);
    for (int j = 0; j < 8; j++) send(ActQry, 0, j, (j == 5) ? 16'h7fff : 16'h8000);
    for (int j = 0; j < 8; j++) send(ActQry, 0, j, (j == 1 || j == 4) ? 16'h0040 : 16'h0000);
    cfg_write(CfgRows, 7'd0);
    cfg_write(CfgTgtLen, 7'd0);
    query_all(16'h0000);
    cfg_write(CfgRows, 7'd100);
    cfg_write(CfgKeyLen, 7'd31);
    cfg_write(CfgTgtLen, 7'd15);
    query_all(16'h7ffc);
    cfg_write(CfgOnehot, 7'd0);
    cfg_write(CfgRows, 7'(LoadRows));
    cfg_write(CfgKeyLen, 7'd0);
    cfg_write(CfgTgtLen, 7'd1);
    send(ActQry, 0, 0, 16'h7fff);
  endtask

  task automatic test_random();
    int sent, klen, p;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(CfgOnehot, 7'($urandom_range(2) == 0));
      p = $urandom_range(9);
      cfg_write(CfgRows, (p == 0) ? 7'd0 : 7'($urandom_range(LoadRows, 1)));
      cfg_write(CfgKeyLen, ($urandom_range(5) == 0) ? 7'($urandom_range(31)) :
                                                      7'($urandom_range(16, 1)));
      cfg_write(CfgTgtLen, ($urandom_range(5) == 0) ? 7'($urandom_range(15)) :
                                                      7'($urandom_range(8, 1)));
      no_gaps = (ph % 3 == 2);
      klen = clamp(klen_reg, 16);
      sent = 0;
      while (sent < 16) begin
        p = $urandom_range(99);
        if (p < 70) begin
          for (int j = 0; j < klen; j++) send(ActQry, $urandom, j, pick_value());
          sent += klen;
        end else if (p < 85) begin
          send($urandom_range(1), $urandom, $urandom, pick_value());
          sent++;
        end else if (p < 92) begin
          send(ActQry, $urandom, $urandom, pick_value());
          sent++;
        end else begin
          send(2'd3, $urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load();
    test_directed();
    test_random();
    settle();
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
